[design/minv_pkg.sv]
// Shared constants for the 3x3 matrix inverse and determinant pipeline.
package minv_pkg;

   localparam int NUM_ENTRIES = 9;
   localparam int NUM_TERMS   = 3;

   // Cofactor k = a[p]*a[q] - a[u]*a[v]; flat index = column*3 + row.
   localparam logic [3:0] COF_IDX [NUM_ENTRIES][4] = '{
      '{4'd4, 4'd8, 4'd7, 4'd5}, '{4'd7, 4'd2, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd4, 4'd2},
      '{4'd6, 4'd5, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd6, 4'd2}, '{4'd3, 4'd2, 4'd0, 4'd5},
      '{4'd3, 4'd7, 4'd6, 4'd4}, '{4'd6, 4'd1, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd3, 4'd1}
   };

   // Row-0 entries used for the determinant expansion.
   localparam logic [3:0] DET_IDX [NUM_TERMS] = '{4'd0, 4'd3, 4'd6};

endpackage

[design/matrix3_inverse_determinant.sv]
// Fully pipelined 3x3 fixed-point matrix inverse and determinant.
//
// One 3x3 matrix is taken per transfer on the req_ stream and one result
// (inverse, determinant, singular flag) is returned per transfer on the rsp_
// stream. A new matrix may enter every cycle while the output is not
// stalled. The restoring divider resolves one quotient bit per stage for all
// nine entries in parallel.
// Entries are signed fixed point with FRAC_BITS fraction bits, column-major.
// Cofactors and the determinant are kept exact; each inverse entry is
// cof * 2^(2*FRAC_BITS) / det truncated toward zero and saturated, and the
// determinant output is det / 2^(2*FRAC_BITS) truncated and saturated. A zero
// determinant raises singular and forces all outputs to zero. When the
// output register is full and not taken, the whole pipeline holds.
module matrix3_inverse_determinant #(
   parameter int ENTRY_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic clock,
   input  logic reset,
   // c0r0, c0r1, c0r2, c1r0, c1r1, c1r2, c2r0, c2r1, c2r2 (lowest first)
   input  logic [((9*ENTRY_WIDTH+7)/8)*8-1:0]  req_tdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // inv_c0r0 .. inv_c2r2 (column-major), det_value (lowest first)
   output logic [((10*ENTRY_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // singular
   output logic                                rsp_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready
);
   import minv_pkg::*;

   localparam int W    = ENTRY_WIDTH;
   localparam int F    = FRAC_BITS;
   localparam int PW   = 2*W;          // entry product
   localparam int CW   = 2*W + 1;      // cofactor, signed
   localparam int HW   = 2*W + 1;      // partial product of det expansion
   localparam int DW   = 3*W + 2;      // determinant, signed
   localparam int DMW  = 3*W + 1;      // determinant magnitude
   localparam int NW   = 2*W + 2*F;    // dividend magnitude
   localparam int RW   = (NW > DMW + W) ? NW : DMW + W;
   localparam int SW   = DMW - 2*F;    // determinant output before saturation
   localparam int XW   = SW + W;
   localparam int NST  = W + 8;
   localparam int OTW  = ((10*W+7)/8)*8;

   // global advance: the output register is the only place a stall is seen
   logic en;
   logic [NST-1:0] vld_ff, vld_in;

   assign en         = ~vld_ff[NST-1] | rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[NST-1];
   assign vld_in     = {vld_ff[NST-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // ---- stage 1: eighteen entry products
   logic signed [W-1:0]  a_in [NUM_ENTRIES];
   logic signed [PW-1:0] prod_ff [2*NUM_ENTRIES], prod_in [2*NUM_ENTRIES];
   logic signed [W-1:0]  ak1_ff [NUM_TERMS], ak1_in [NUM_TERMS];

   always_comb begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         a_in[i] = $signed(req_tdata[i*W +: W]);
      end
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         prod_in[2*i]   = a_in[COF_IDX[i][0]] * a_in[COF_IDX[i][1]];
         prod_in[2*i+1] = a_in[COF_IDX[i][2]] * a_in[COF_IDX[i][3]];
      end
      for (int t = 0; t < NUM_TERMS; t++) begin
         ak1_in[t] = a_in[DET_IDX[t]];
      end
   end

   // ---- stage 2: cofactors
   logic signed [CW-1:0] cof2_ff [NUM_ENTRIES], cof2_in [NUM_ENTRIES];
   logic signed [W-1:0]  ak2_ff [NUM_TERMS];

   always_comb begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         cof2_in[i] = CW'(prod_ff[2*i]) - CW'(prod_ff[2*i+1]);
      end
   end

   // ---- stage 3: determinant partial products, cofactor split at W bits
   logic signed [HW-1:0] pplo_ff [NUM_TERMS], pplo_in [NUM_TERMS];
   logic signed [HW-1:0] pphi_ff [NUM_TERMS], pphi_in [NUM_TERMS];
   logic signed [CW-1:0] cof3_ff [NUM_ENTRIES];

   always_comb begin
      for (int t = 0; t < NUM_TERMS; t++) begin
         pplo_in[t] = ak2_ff[t] * $signed({1'b0, cof2_ff[t][W-1:0]});
         pphi_in[t] = ak2_ff[t] * $signed(cof2_ff[t][CW-1:W]);
      end
   end

   // ---- stage 4: recombine each term
   logic signed [DW-1:0] term_ff [NUM_TERMS], term_in [NUM_TERMS];
   logic signed [CW-1:0] cof4_ff [NUM_ENTRIES];

   always_comb begin
      for (int t = 0; t < NUM_TERMS; t++) begin
         term_in[t] = (DW'(pphi_ff[t]) <<< W) + DW'(pplo_ff[t]);
      end
   end

   // ---- stage 5: determinant
   logic signed [DW-1:0] det_ff, det_in;
   logic signed [CW-1:0] cof5_ff [NUM_ENTRIES];

   assign det_in = term_ff[0] + term_ff[1] + term_ff[2];

   // ---- stage 6: magnitudes, signs, determinant output
   logic [DMW-1:0] dabs6_ff, dabs6_in;
   logic [NW-1:0]  num_ff [NUM_ENTRIES], num_in [NUM_ENTRIES];
   logic [8:0]     neg6_ff, neg6_in;
   logic           sing6_ff, sing6_in;
   logic [W-1:0]   detv6_ff, detv6_in;
   logic [DW-1:0]  dneg_val;
   logic [CW-1:0]  cneg_val;
   logic [XW-1:0]  dsh;
   logic           dneg;

   always_comb begin
      dneg     = det_ff[DW-1];
      dneg_val = -det_ff;
      dabs6_in = dneg ? dneg_val[DMW-1:0] : det_ff[DMW-1:0];
      sing6_in = (det_ff == '0);
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         cneg_val   = -cof5_ff[i];
         num_in[i]  = cof5_ff[i][CW-1] ? {cneg_val[PW-1:0], {(2*F){1'b0}}}
                                       : {cof5_ff[i][PW-1:0], {(2*F){1'b0}}};
         neg6_in[i] = cof5_ff[i][CW-1] ^ dneg;
      end
      dsh = XW'(dabs6_in[DMW-1:2*F]);
      if (dneg) begin
         if (dsh > XW'({1'b1, {(W-1){1'b0}}})) begin
            detv6_in = {1'b1, {(W-1){1'b0}}};
         end else begin
            detv6_in = -dsh[W-1:0];
         end
      end else begin
         if (dsh > XW'({(W-1){1'b1}})) begin
            detv6_in = {1'b0, {(W-1){1'b1}}};
         end else begin
            detv6_in = dsh[W-1:0];
         end
      end
   end

   // ---- stage 7 and divider stages; index 0 is the setup stage
   logic [RW-1:0]  rem_ff  [0:W][NUM_ENTRIES];
   logic [W-1:0]   q_ff    [0:W][NUM_ENTRIES];
   logic [DMW-1:0] dabs_ff [0:W];
   logic [8:0]     neg_ff  [0:W];
   logic [8:0]     ovf_ff  [0:W];
   logic           sing_ff [0:W];
   logic [W-1:0]   detv_ff [0:W];
   logic [8:0]     ovf_in;

   // quotient of 2^W or more saturates; the divider then runs on W bits
   always_comb begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         ovf_in[i] = RW'(num_ff[i]) >= (RW'(dabs6_ff) << W);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff  <= prod_in;
         ak1_ff   <= ak1_in;
         cof2_ff  <= cof2_in;
         ak2_ff   <= ak1_ff;
         pplo_ff  <= pplo_in;
         pphi_ff  <= pphi_in;
         cof3_ff  <= cof2_ff;
         term_ff  <= term_in;
         cof4_ff  <= cof3_ff;
         det_ff   <= det_in;
         cof5_ff  <= cof4_ff;
         dabs6_ff <= dabs6_in;
         num_ff   <= num_in;
         neg6_ff  <= neg6_in;
         sing6_ff <= sing6_in;
         detv6_ff <= detv6_in;
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            rem_ff[0][i] <= RW'(num_ff[i]);
            q_ff[0][i]   <= '0;
         end
         dabs_ff[0] <= dabs6_ff;
         neg_ff[0]  <= neg6_ff;
         ovf_ff[0]  <= ovf_in;
         sing_ff[0] <= sing6_ff;
         detv_ff[0] <= detv6_ff;
      end
   end

   // restoring divider: stage k resolves quotient bit W-k
   for (genvar k = 1; k <= W; k++) begin : g_div
      logic [RW-1:0] rem_in [NUM_ENTRIES];
      logic [W-1:0]  q_in   [NUM_ENTRIES];
      logic [RW:0]   diff;

      always_comb begin
         diff = '0;
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            diff = {1'b0, rem_ff[k-1][i]} - {1'b0, RW'(dabs_ff[k-1]) << (W-k)};
            q_in[i] = q_ff[k-1][i];
            if (!diff[RW]) begin
               rem_in[i]     = diff[RW-1:0];
               q_in[i][W-k]  = 1'b1;
            end else begin
               rem_in[i]     = rem_ff[k-1][i];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            q_ff[k]    <= q_in;
            dabs_ff[k] <= dabs_ff[k-1];
            neg_ff[k]  <= neg_ff[k-1];
            ovf_ff[k]  <= ovf_ff[k-1];
            sing_ff[k] <= sing_ff[k-1];
            detv_ff[k] <= detv_ff[k-1];
         end
      end
   end

   // ---- output stage: sign, saturation, singular override
   logic [OTW-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic           rsp_tuser_ff;
   logic [W-1:0]   qv;

   always_comb begin
      rsp_tdata_in = '0;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         qv = q_ff[W][i];
         if (sing_ff[W]) begin
            rsp_tdata_in[i*W +: W] = '0;
         end else if (neg_ff[W][i]) begin
            if (ovf_ff[W][i] || (qv > {1'b1, {(W-1){1'b0}}})) begin
               rsp_tdata_in[i*W +: W] = {1'b1, {(W-1){1'b0}}};
            end else begin
               rsp_tdata_in[i*W +: W] = -qv;
            end
         end else begin
            if (ovf_ff[W][i] || qv[W-1]) begin
               rsp_tdata_in[i*W +: W] = {1'b0, {(W-1){1'b1}}};
            end else begin
               rsp_tdata_in[i*W +: W] = qv;
            end
         end
      end
      rsp_tdata_in[9*W +: W] = sing_ff[W] ? '0 : detv_ff[W];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tuser_ff <= sing_ff[W];
      end
   end

   assign rsp_tdata = rsp_tdata_ff;
   assign rsp_tuser = rsp_tuser_ff;

endmodule
